// ===== hdl/qaco_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaco_pkg
// Shared widths, types and control groups for the quadrilateral area block.
// ----------------------------------------------------------------------------
package qaco_pkg;

    localparam int COORD_W  = 24;
    localparam int AREA_W   = 51;
    localparam int NUM_VERT = 4;
    localparam int NUM_PAIR = 2;
    localparam int IDX_W    = $clog2(NUM_VERT);
    localparam int PROD_W   = 2 * COORD_W;
    localparam int SUM_W    = (PROD_W + 3 > AREA_W) ? PROD_W + 3 : AREA_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [AREA_W-1:0]  t_area;
    typedef logic        [IDX_W-1:0]   t_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_idx   idx;
    } t_vertex;

    typedef struct packed {
        logic en_prod;
        logic en_diff;
    } t_lane_ctl;

endpackage

// ===== hdl/qaco_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaco_sort
// Stable rank sort of the four vertices by x, then a y swap within each pair,
// registered in canonical order: left-low, right-low, right-high, left-high.
// ----------------------------------------------------------------------------
module qaco_sort
    import qaco_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_coord  i_x [NUM_VERT],
    input  t_coord  i_y [NUM_VERT],
    output t_vertex o_vert [NUM_VERT]
);

    t_idx    rank [NUM_VERT];
    t_vertex ord  [NUM_VERT];
    t_vertex fin  [NUM_VERT];
    t_vertex r_vert [NUM_VERT];

    always_comb begin
        for (int i = 0; i < NUM_VERT; i++) begin
            rank[i] = '0;
            for (int j = 0; j < NUM_VERT; j++) begin
                if ((i_x[j] < i_x[i]) || ((i_x[j] == i_x[i]) && (j < i))) begin
                    rank[i] = rank[i] + t_idx'(1);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_VERT; r++) begin
            ord[r] = '0;
            for (int i = 0; i < NUM_VERT; i++) begin
                if (rank[i] == t_idx'(r)) begin
                    ord[r].x   = i_x[i];
                    ord[r].y   = i_y[i];
                    ord[r].idx = t_idx'(i);
                end
            end
        end
    end

    always_comb begin
        if (ord[1].y < ord[0].y) begin
            fin[0] = ord[1];
            fin[3] = ord[0];
        end else begin
            fin[0] = ord[0];
            fin[3] = ord[1];
        end
        if (ord[3].y < ord[2].y) begin
            fin[1] = ord[3];
            fin[2] = ord[2];
        end else begin
            fin[1] = ord[2];
            fin[2] = ord[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vert <= fin;
        end
    end

    assign o_vert = r_vert;

endmodule

// ===== hdl/qaco_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaco_lane
// One shoelace term: registers both cross products of an edge, then their
// registered difference at full sum width.
// ----------------------------------------------------------------------------
module qaco_lane
    import qaco_pkg::*;
(
    input  logic      i_clk,
    input  t_lane_ctl i_ctl,
    input  t_vertex   i_p,
    input  t_vertex   i_q,
    output t_sum      o_diff
);

    t_prod r_pq;
    t_prod r_qp;
    t_sum  r_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            r_pq <= t_prod'(i_p.x) * t_prod'(i_q.y);
            r_qp <= t_prod'(i_q.x) * t_prod'(i_p.y);
        end
        if (i_ctl.en_diff) begin
            r_diff <= t_sum'(r_pq) - t_sum'(r_qp);
        end
    end

    assign o_diff = r_diff;

endmodule

// ===== hdl/qaco_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaco_merge
// Adds the lane terms into the doubled area and holds it in the output
// register together with the ordered vertex indices.
// ----------------------------------------------------------------------------
module qaco_merge
    import qaco_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sum  i_diff [NUM_VERT],
    input  t_idx  i_idx  [NUM_VERT],
    output t_area o_area,
    output t_idx  o_idx  [NUM_VERT]
);

    t_sum n_sum;
    t_sum r_sum;
    t_idx r_idx [NUM_VERT];

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NUM_VERT; i++) begin
            n_sum = n_sum + i_diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_idx <= i_idx;
        end
    end

    assign o_area = r_sum[AREA_W-1:0];
    assign o_idx  = r_idx;

endmodule

// ===== hdl/quad_area_canonical_order.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_area_canonical_order
// Canonical vertex ordering and exact doubled shoelace area of a quadrilateral.
// ----------------------------------------------------------------------------
// Each input word carries four vertices as signed x,y pairs. Each output word
// carries twice the signed area over the canonical order (left-low, right-low,
// right-high, left-high) and the input index of each ordered vertex.
// Both channels use valid and ready; a word moves when both are high.
// From acceptance to o_valid a word passes the sort register, the
// product registers of the four lanes, the lane difference registers and the
// output register. Throughput is one word per cycle while the receiver takes
// words, set by the four-stage pipeline with one edge lane per shoelace term.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and new words are taken while a result waits at the output.
// When the receiver stalls, the output holds its word and the stages behind it
// fill; o_ready drops only once all four stages hold words.
// A synchronous active-low reset empties the pipeline, dropping any words in
// flight; no word is invented across it.
// ----------------------------------------------------------------------------
module quad_area_canonical_order
    import qaco_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_ax,
    input  t_coord i_ay,
    input  t_coord i_bx,
    input  t_coord i_by_coord,
    input  t_coord i_cx,
    input  t_coord i_cy,
    input  t_coord i_dx,
    input  t_coord i_dy,
    output logic   o_valid,
    input  logic   i_ready,
    output t_area  o_double_area,
    output t_idx   o_first_index,
    output t_idx   o_second_index,
    output t_idx   o_third_index,
    output t_idx   o_fourth_index
);

    logic      r_v_sort;
    logic      r_v_prod;
    logic      r_v_diff;
    logic      r_v_out;
    logic      en_sort;
    logic      en_prod;
    logic      en_diff;
    logic      en_out;
    t_lane_ctl lane_ctl;
    t_coord    in_x [NUM_VERT];
    t_coord    in_y [NUM_VERT];
    t_vertex   vert [NUM_VERT];
    t_sum      diff [NUM_VERT];
    t_idx      r_idx_prod [NUM_VERT];
    t_idx      r_idx_diff [NUM_VERT];
    t_idx      out_idx [NUM_VERT];

    assign en_out  = !r_v_out  || i_ready;
    assign en_diff = !r_v_diff || en_out;
    assign en_prod = !r_v_prod || en_diff;
    assign en_sort = !r_v_sort || en_prod;

    assign lane_ctl.en_prod = en_prod;
    assign lane_ctl.en_diff = en_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sort <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_diff <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (en_sort) begin
                r_v_sort <= i_valid;
            end
            if (en_prod) begin
                r_v_prod <= r_v_sort;
            end
            if (en_diff) begin
                r_v_diff <= r_v_prod;
            end
            if (en_out) begin
                r_v_out <= r_v_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_VERT; i++) begin
            if (en_prod) begin
                r_idx_prod[i] <= vert[i].idx;
            end
            if (en_diff) begin
                r_idx_diff[i] <= r_idx_prod[i];
            end
        end
    end

    assign in_x[0] = i_ax;
    assign in_y[0] = i_ay;
    assign in_x[1] = i_bx;
    assign in_y[1] = i_by_coord;
    assign in_x[2] = i_cx;
    assign in_y[2] = i_cy;
    assign in_x[3] = i_dx;
    assign in_y[3] = i_dy;

    qaco_sort u_sort (
        .i_clk  (i_clk),
        .i_en   (en_sort),
        .i_x    (in_x),
        .i_y    (in_y),
        .o_vert (vert)
    );

    for (genvar g = 0; g < NUM_VERT; g++) begin : g_lane
        qaco_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_p    (vert[g]),
            .i_q    (vert[(g + 1) % NUM_VERT]),
            .o_diff (diff[g])
        );
    end

    qaco_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en_out),
        .i_diff (diff),
        .i_idx  (r_idx_diff),
        .o_area (o_double_area),
        .o_idx  (out_idx)
    );

    assign o_ready        = en_sort;
    assign o_valid        = r_v_out;
    assign o_first_index  = out_idx[0];
    assign o_second_index = out_idx[1];
    assign o_third_index  = out_idx[2];
    assign o_fourth_index = out_idx[3];

endmodule

// ===== bench/quad_area_canonical_order_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_area_canonical_order_tb
// Self-checking bench for the canonical-order quadrilateral area block.
// ----------------------------------------------------------------------------
// A short table of directed quadrilaterals (extremes, ties, degenerate and
// crossed shapes) is followed by about a thousand random ones. Each accepted
// word with no stored result runs through a local model of the vertex sort
// and the shoelace sum; each output word is compared field by field with the
// oldest prediction. Both sides idle at random, the receiver holds off once
// for a long stretch, and the sender once waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module quad_area_canonical_order_tb;
    import qaco_pkg::*;

    localparam int     NUM_RANDOM  = 1035;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     LONG_HOLD   = 120;
    localparam t_coord C_MIN       = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_coord C_MAX       = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct packed {
        t_coord [3:0] x;
        t_coord [3:0] y;
    } quad_t;

    typedef struct packed {
        t_area       area;
        t_idx  [3:0] idx;
    } area_result_t;

    typedef struct packed {
        quad_t        quad;
        logic         has_ref;
        area_result_t ref_result;
    } quad_row_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy, i_dx, i_dy;
    logic   o_valid;
    logic   i_ready;
    t_area  o_double_area;
    t_idx   o_first_index, o_second_index, o_third_index, o_fourth_index;

    area_result_t expected_areas[$];
    quad_row_t    quad_rows[$];
    area_result_t cur_ref;
    logic         cur_has_ref;
    logic         no_idle;
    int           mismatches;
    int           results_seen;
    int           cycle_count;
    int           stall_left;
    logic         long_hold_done;

    quad_area_canonical_order uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ax           (i_ax),
        .i_ay           (i_ay),
        .i_bx           (i_bx),
        .i_by_coord     (i_by_coord),
        .i_cx           (i_cx),
        .i_cy           (i_cy),
        .i_dx           (i_dx),
        .i_dy           (i_dy),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_double_area  (o_double_area),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_third_index  (o_third_index),
        .o_fourth_index (o_fourth_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic area_result_t shoelace_canonical(quad_t q);
        t_coord              xs[4];
        t_coord              ys[4];
        t_idx                ord[4];
        t_idx                fin[4];
        t_idx                t;
        int                  j;
        logic signed [63:0]  xp, yp, xn, yn;
        logic signed [63:0]  acc;
        area_result_t        r;
        for (int i = 0; i < 4; i++) begin
            xs[i]  = q.x[i];
            ys[i]  = q.y[i];
            ord[i] = t_idx'(i);
        end
        for (int i = 1; i < 4; i++) begin
            t = ord[i];
            j = i;
            while (j > 0 && $signed(xs[t]) < $signed(xs[ord[j-1]])) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = t;
        end
        if ($signed(ys[ord[1]]) < $signed(ys[ord[0]])) begin
            t = ord[0]; ord[0] = ord[1]; ord[1] = t;
        end
        if ($signed(ys[ord[3]]) < $signed(ys[ord[2]])) begin
            t = ord[2]; ord[2] = ord[3]; ord[3] = t;
        end
        fin[0] = ord[0];
        fin[1] = ord[2];
        fin[2] = ord[3];
        fin[3] = ord[1];
        acc = 0;
        for (int i = 0; i < 4; i++) begin
            xp  = $signed(xs[fin[i]]);
            yp  = $signed(ys[fin[i]]);
            xn  = $signed(xs[fin[(i + 1) % 4]]);
            yn  = $signed(ys[fin[(i + 1) % 4]]);
            acc = acc + xp * yn - xn * yp;
        end
        r.area = acc[AREA_W-1:0];
        for (int i = 0; i < 4; i++) r.idx[i] = fin[i];
        return r;
    endfunction

    function automatic quad_t mk_quad(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                                      t_coord cx, t_coord cy, t_coord dx, t_coord dy);
        quad_t q;
        q.x[0] = ax; q.y[0] = ay;
        q.x[1] = bx; q.y[1] = by;
        q.x[2] = cx; q.y[2] = cy;
        q.x[3] = dx; q.y[3] = dy;
        return q;
    endfunction

    function automatic area_result_t mk_result(t_area area, t_idx i0, t_idx i1,
                                               t_idx i2, t_idx i3);
        area_result_t r;
        r.area   = area;
        r.idx[0] = i0;
        r.idx[1] = i1;
        r.idx[2] = i2;
        r.idx[3] = i3;
        return r;
    endfunction

    function automatic t_coord rand_coord(int style);
        case (style)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 8)) - 4);
            default: begin
                case ($urandom_range(0, 4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return t_coord'(0);
                    3: return t_coord'(-1);
                    default: return t_coord'(1);
                endcase
            end
        endcase
    endfunction

    function automatic quad_t rand_quad();
        quad_t  q;
        int     pick;
        t_coord xa, xb;
        pick = $urandom_range(0, 99);
        xa   = rand_coord(0);
        xb   = rand_coord(0);
        for (int i = 0; i < 4; i++) begin
            if (pick < 40) begin
                q.x[i] = rand_coord(0);
                q.y[i] = rand_coord(0);
            end else if (pick < 65) begin
                q.x[i] = rand_coord(1);
                q.y[i] = rand_coord(1);
            end else if (pick < 80) begin
                q.x[i] = rand_coord(2);
                q.y[i] = rand_coord(2);
            end else begin
                q.x[i] = $urandom_range(0, 1) ? xa : xb;
                q.y[i] = $urandom_range(0, 3) == 0 ? rand_coord(1) : rand_coord(0);
            end
        end
        return q;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, logic signed [63:0] exp_v,
                               logic signed [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic send_quad(quad_t q, logic has_ref, area_result_t ref_r);
        int gap;
        @(negedge i_clk);
        i_ax        <= q.x[0];
        i_ay        <= q.y[0];
        i_bx        <= q.x[1];
        i_by_coord  <= q.y[1];
        i_cx        <= q.x[2];
        i_cy        <= q.y[2];
        i_dx        <= q.x[3];
        i_dy        <= q.y[3];
        cur_has_ref = has_ref;
        cur_ref     = ref_r;
        i_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_areas.size() != 0) @(negedge i_clk);
    endtask

    task automatic add_row(quad_t q, logic has_ref, area_result_t ref_r);
        quad_row_t row;
        row.quad       = q;
        row.has_ref    = has_ref;
        row.ref_result = ref_r;
        quad_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quad_area_canonical_order_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        area_result_t exp_r;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_areas.size() == 0) begin
                    $error("output word with no prediction waiting");
                    mismatches++;
                end else begin
                    exp_r = expected_areas.pop_front();
                    check_field("double_area", exp_r.area, o_double_area);
                    check_field("first_index", {1'b0, exp_r.idx[0]}, {1'b0, o_first_index});
                    check_field("second_index", {1'b0, exp_r.idx[1]},
                                {1'b0, o_second_index});
                    check_field("third_index", {1'b0, exp_r.idx[2]}, {1'b0, o_third_index});
                    check_field("fourth_index", {1'b0, exp_r.idx[3]},
                                {1'b0, o_fourth_index});
                end
            end
            if (i_valid && o_ready) begin
                if (cur_has_ref) begin
                    expected_areas.push_back(cur_ref);
                end else begin
                    expected_areas.push_back(shoelace_canonical(
                        mk_quad(i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy, i_dx, i_dy)));
                end
            end
        end
    end

    always begin
        @(negedge i_clk);
        if (results_seen >= 300 && !long_hold_done) begin
            long_hold_done = 1'b1;
            i_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge i_clk);
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0) stall_left = idle_gap() + 1;
        end
    end

    initial begin
        area_result_t none;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_ax           = '0;
        i_ay           = '0;
        i_bx           = '0;
        i_by_coord     = '0;
        i_cx           = '0;
        i_cy           = '0;
        i_dx           = '0;
        i_dy           = '0;
        cur_has_ref    = 1'b0;
        cur_ref        = '0;
        no_idle        = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        cycle_count    = 0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        none           = '0;

        add_row(mk_quad(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_result(0, 0, 2, 3, 1));
        add_row(mk_quad(0, 0, 1, 0, 1, 1, 0, 1), 1'b1, mk_result(2, 0, 1, 2, 3));
        add_row(mk_quad(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX), 1'b1,
                mk_result(t_area'(64'sd562949886312450), 1, 2, 0, 3));
        add_row(mk_quad(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b0, none);
        add_row(mk_quad(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b0, none);
        add_row(mk_quad(5, 3, 5, -1, 5, 2, 5, -7), 1'b0, none);
        add_row(mk_quad(1, 4, 1, 4, 2, 4, 2, 4), 1'b0, none);
        add_row(mk_quad(3, 3, 0, 3, 3, 0, 0, 0), 1'b0, none);
        add_row(mk_quad(0, 0, 10, -100, 0, 1, 10, -50), 1'b0, none);
        add_row(mk_quad(-3, -3, 0, 0, 3, 3, 6, 6), 1'b0, none);
        add_row(mk_quad(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA,
                        24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'h555555), 1'b0, none);
        add_row(mk_quad(-1, -1, 1, 1, -1, 1, 1, -1), 1'b0, none);
        add_row(mk_quad(C_MIN, 0, C_MAX, 0, C_MAX, 0, C_MIN, 0), 1'b0, none);
        add_row(mk_quad(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN), 1'b0, none);
        add_row(mk_quad(2, 0, 2, 5, 2, -5, -9, 1), 1'b0, none);
        add_row(mk_quad(C_MIN, 0, 0, C_MIN, C_MAX, 0, 0, C_MAX), 1'b0, none);
        add_row(mk_quad(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN), 1'b0, none);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (quad_rows[k]) send_quad(quad_rows[k].quad, quad_rows[k].has_ref,
                                         quad_rows[k].ref_result);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle = (n >= 450 && n < 600);
            if (n == 800) wait_drained();
            send_quad(rand_quad(), 1'b0, none);
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("quad_area_canonical_order_tb: PASS");
        end else begin
            $display("quad_area_canonical_order_tb: FAIL");
        end
        $finish;
    end

endmodule
